// ===== sv/stable_priority_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue_core_macros.svh
// assertion macros shared by the queue checker
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 8;
	localparam int OCC_W   = 5;
	localparam int S_TDATA_W = 40;  // value, priority_req
	localparam int M_TDATA_W = 40;  // pop_value, occupancy, zero fill

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic                push;
		logic                pop;
		logic [PRIO_W-1:0]   prio;
		logic [VALUE_W-1:0]  value;
	} cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, inserts, or takes from a neighbor
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                       clk,
	input  spq_pkg::cell_cmd_t         cmd,
	input  logic                       in_range,
	input  logic                       left_ge,
	input  logic [spq_pkg::VALUE_W-1:0] left_value,
	input  logic [spq_pkg::PRIO_W-1:0]  left_prio,
	input  logic [spq_pkg::VALUE_W-1:0] right_value,
	input  logic [spq_pkg::PRIO_W-1:0]  right_prio,
	output logic                       ge,
	output logic [spq_pkg::VALUE_W-1:0] value,
	output logic [spq_pkg::PRIO_W-1:0]  prio
);
	import spq_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic [PRIO_W-1:0]  prio_q;

	// entry stays ahead of the new one
	assign ge    = in_range && (prio_q >= cmd.prio);
	assign value = value_q;
	assign prio  = prio_q;

	// push and pop never come together; with neither the slot holds
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!ge) begin
				if (left_ge) begin
					value_q <= cmd.value;
					prio_q  <= cmd.prio;
				end else begin
					value_q <= left_value;
					prio_q  <= left_prio;
				end
			end
		end else if (cmd.pop) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

// ===== sv/stable_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// bounded priority queue kept sorted in a row of shift-insert cells
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  s_      | in  | [31:0] value, [39:32] priority_req | [0] kind (0 push, 1 pop)
//  m_      | out | [31:0] pop_value, [36:32] occupancy| [1:0] status
//
//  one beat in, one beat out; every cell compares its priority with the new
//  one in parallel, so an item is taken every cycle while the input is not
//  stalled, and its result is registered in the output register
//  the input stalls only while a result waits in the output register
//  reset clears the entry count and the output valid; the cells hold no reset
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,   // value, priority_req
	input  logic [0:0]                   s_tuser,   // kind
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,   // pop_value, occupancy, zeros
	output logic [1:0]                   m_tuser    // status
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// entry count, the only control state of the chain
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	// output register
	logic               out_valid_q;
	logic [VALUE_W-1:0] pop_value_q;
	status_t            status_q;
	logic [OCC_W-1:0]   occ_q;

	logic               accept;
	logic               is_pop;
	logic               full;
	logic               empty;
	cell_cmd_t          cmd;
	status_t            status_next;
	logic [VALUE_W-1:0] pop_value_next;

	// cell outputs, one slot per cell
	logic               cell_ge    [CAPACITY];
	logic [VALUE_W-1:0] cell_value [CAPACITY];
	logic [PRIO_W-1:0]  cell_prio  [CAPACITY];

	// a new beat enters when the output slot is free or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_pop   = (s_tuser[0] == KIND_POP);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// drops and empty pops leave the chain untouched
	assign cmd.push  = accept && !is_pop && !full;
	assign cmd.pop   = accept && is_pop && !empty;
	assign cmd.value = s_tdata[VALUE_W-1:0];
	assign cmd.prio  = s_tdata[VALUE_W +: PRIO_W];

	// the cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               in_range;
		logic               left_ge;
		logic [VALUE_W-1:0] left_value;
		logic [PRIO_W-1:0]  left_prio;
		logic [VALUE_W-1:0] right_value;
		logic [PRIO_W-1:0]  right_prio;

		assign in_range = (CNT_W'(i) < count_q);

		// head: nothing ahead, so a new entry lands here unless the head stays
		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign left_value = cmd.value;
			assign left_prio  = cmd.prio;
		end else begin : g_body
			assign left_ge    = cell_ge[i-1];
			assign left_value = cell_value[i-1];
			assign left_prio  = cell_prio[i-1];
		end

		// tail: nothing behind, the slot falls out of range on a pop
		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
			assign right_prio  = cell_prio[i];
		end else begin : g_link
			assign right_value = cell_value[i+1];
			assign right_prio  = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.in_range    (in_range),
			.left_ge     (left_ge),
			.left_value  (left_value),
			.left_prio   (left_prio),
			.right_value (right_value),
			.right_prio  (right_prio),
			.ge          (cell_ge[i]),
			.value       (cell_value[i]),
			.prio        (cell_prio[i])
		);
	end

	// result of the beat being taken
	always_comb begin
		count_next     = count_q;
		status_next    = ST_PUSHED;
		pop_value_next = '0;
		priority if (cmd.push) begin
			count_next  = count_q + CNT_W'(1);
			status_next = ST_PUSHED;
		end else if (cmd.pop) begin
			count_next     = count_q - CNT_W'(1);
			status_next    = ST_POPPED;
			pop_value_next = cell_value[0];
		end else if (is_pop) begin
			status_next    = ST_EMPTY;
			pop_value_next = MOST_NEGATIVE;
		end else begin
			status_next = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= pop_value_next;
			status_q    <= status_next;
			occ_q       <= OCC_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-VALUE_W-OCC_W){1'b0}}, occ_q, pop_value_q};
	assign m_tuser  = status_q;

endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "stable_priority_queue_core_macros.svh"

module spq_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tready,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [1:0]                   m_tuser
);
	import spq_pkg::*;

	localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

	logic [OCC_W-1:0]   occ;
	logic [VALUE_W-1:0] pop_value;
	logic               stalled;
	logic               full_beat;
	logic               empty_beat;

	assign occ        = m_tdata[VALUE_W +: OCC_W];
	assign pop_value  = m_tdata[VALUE_W-1:0];
	assign stalled    = m_tvalid && !m_tready;
	assign full_beat  = m_tvalid && (m_tuser == ST_FULL);
	assign empty_beat = m_tvalid && (m_tuser == ST_EMPTY);

	// a stalled result beat holds
	`SPQ_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable({m_tuser, m_tdata}), "stalled beat changed")

	// no new beat is taken while a result waits
	`SPQ_ASSERT_SAME(a_no_overrun, stalled, !s_tready, "input taken over a waiting result")

	// a dropped push only happens at capacity
	`SPQ_ASSERT_SAME(a_full_occ, full_beat, occ == CAP_OCC && pop_value == '0, "drop below capacity")

	// an empty pop leaves nothing stored and returns the sentinel
	`SPQ_ASSERT_SAME(a_empty_pop, empty_beat, occ == '0 && pop_value == MOST_NEGATIVE, "bad empty pop")

	// occupancy never passes capacity
	`SPQ_ASSERT_SAME(a_occ_bound, m_tvalid, (CAPACITY > 31) || (occ <= CAP_OCC), "occupancy too high")

endmodule

bind stable_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
